// ===== rtl/core/bmpdec_pkg.sv =====
`default_nettype none

package bmpdec_pkg;

    // Error codes carried in an error result
    typedef enum logic [2:0] {
        ERR_MAGIC    = 3'd0,
        ERR_VERSION  = 3'd1,
        ERR_HEADER   = 3'd2,
        ERR_BPP      = 3'd3,
        ERR_COMPRESS = 3'd4,
        ERR_SIZE     = 3'd5,
        ERR_OFFSET   = 3'd6,
        ERR_TRUNC    = 3'd7
    } err_code_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_ERROR = 1'b1
    } result_kind_t;

    // Header constants
    localparam logic [7:0]  MAGIC_B        = 8'h42;
    localparam logic [7:0]  MAGIC_M        = 8'h4D;
    localparam logic [31:0] HDR_INFO       = 32'd40;
    localparam logic [31:0] HDR_CORE       = 32'd12;
    localparam logic [31:0] HDR_V2         = 32'd64;
    localparam logic [31:0] HDR_V4         = 32'd108;
    localparam logic [31:0] HDR_V5         = 32'd124;
    localparam logic [15:0] BPP_24         = 16'd24;
    localparam logic [31:0] FILE_HDR_BYTES = 32'd14;
    localparam logic [31:0] INFO_HDR_END   = 32'd31;
    localparam logic [31:0] CORE_HDR_END   = 32'd25;

    localparam int TDATA_W = 56;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic [11:0]  column;
        logic [11:0]  stored_row;
        logic         last_pixel;
        err_code_t    error_code;
    } result_t;

    typedef struct packed {
        logic error_latched;
        logic image_done;
    } parse_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmpdec_parse.sv =====
`default_nettype none

module bmpdec_parse #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   take,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   start_of_file,
    input  wire logic                   end_of_file,
    output logic                        res_valid,
    output bmpdec_pkg::result_t         res,
    output bmpdec_pkg::parse_stat_t     stat
);
    import bmpdec_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIMENSION + 1);

    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      hdr_len_reg, hdr_len_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      field_reg, field_next;
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      held_reg, held_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [1:0]       pad_reg, pad_next;
    logic             err_latched_reg, err_latched_next;
    logic             done_reg, done_next;

    logic             err_hit, pix_hit, last_hit;
    err_code_t        err_code;
    logic [CNT_W-1:0] pix_col, pix_row;
    logic [31:0]      hdr_end;
    logic             big_hdr;
    logic             size_fail, offset_fail;

    function automatic logic [31:0] place(input logic [7:0] b, input logic [1:0] lane);
        return 32'(b) << {lane, 3'b000};
    endfunction

    function automatic logic size_bad(input logic [31:0] v);
        return (v == 32'd0) || (v > 32'(MAX_DIMENSION));
    endfunction

    // Header fields are final by the last header byte, so check from the registers
    assign size_fail   = size_bad(width_reg) || size_bad(height_reg);
    assign offset_fail = {1'b0, offset_reg} < (33'(FILE_HDR_BYTES) + {1'b0, hdr_len_reg});

    always_comb begin
        pos_next         = pos_reg;
        hdr_len_next     = hdr_len_reg;
        offset_next      = offset_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        field_next       = field_reg;
        phase_next       = phase_reg;
        held_next        = held_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pad_next         = pad_reg;
        err_latched_next = err_latched_reg;
        done_next        = done_reg;
        err_hit          = 1'b0;
        err_code         = ERR_MAGIC;
        pix_hit          = 1'b0;
        last_hit         = 1'b0;
        pix_col          = '0;
        pix_row          = '0;
        big_hdr          = 1'b0;
        hdr_end          = CORE_HDR_END;

        if (take) begin
            if (start_of_file) begin
                pos_next         = '0;
                hdr_len_next     = '0;
                offset_next      = '0;
                width_next       = '0;
                height_next      = '0;
                field_next       = '0;
                phase_next       = '0;
                held_next        = '0;
                col_next         = '0;
                row_next         = '0;
                pad_next         = '0;
                err_latched_next = 1'b0;
                done_next        = 1'b0;
            end

            big_hdr = (hdr_len_next == HDR_INFO);
            hdr_end = big_hdr ? INFO_HDR_END : CORE_HDR_END;

            if (!err_latched_next && !done_next) begin
                if (pos_next == 32'd0) begin
                    if (data_byte != MAGIC_B) begin
                        err_hit  = 1'b1;
                        err_code = ERR_MAGIC;
                    end
                end else if (pos_next == 32'd1) begin
                    if (data_byte != MAGIC_M) begin
                        err_hit  = 1'b1;
                        err_code = ERR_MAGIC;
                    end
                end else if (pos_next >= 32'd10 && pos_next <= 32'd13) begin
                    offset_next = offset_next | place(data_byte, pos_next[1:0] - 2'd2);
                end else if (pos_next >= 32'd14 && pos_next <= 32'd17) begin
                    hdr_len_next = hdr_len_next | place(data_byte, pos_next[1:0] - 2'd2);
                    if (pos_next == 32'd17 && hdr_len_next != HDR_INFO
                            && hdr_len_next != HDR_CORE) begin
                        err_hit = 1'b1;
                        if (hdr_len_next == HDR_V2 || hdr_len_next == HDR_V4
                                || hdr_len_next == HDR_V5) begin
                            err_code = ERR_VERSION;
                        end else begin
                            err_code = ERR_HEADER;
                        end
                    end
                end else if (pos_next > 32'd17) begin
                    if (pos_next <= hdr_end) begin
                        // Capture dimensions: 32-bit fields or 16-bit fields
                        if (big_hdr) begin
                            if (pos_next <= 32'd21) begin
                                width_next = width_next | place(data_byte, pos_next[1:0] - 2'd2);
                            end else if (pos_next <= 32'd25) begin
                                height_next = height_next
                                            | place(data_byte, pos_next[1:0] - 2'd2);
                            end
                        end else begin
                            if (pos_next <= 32'd19) begin
                                width_next = width_next | place(data_byte, pos_next[1:0] - 2'd2);
                            end else if (pos_next <= 32'd21) begin
                                height_next = height_next | place(data_byte, pos_next[1:0]);
                            end
                        end

                        if (pos_next == hdr_end - 32'd3 || pos_next == hdr_end - 32'd1) begin
                            field_next = {8'd0, data_byte};
                        end else if (pos_next == hdr_end - 32'd2 || pos_next == hdr_end) begin
                            field_next = field_next | {data_byte, 8'd0};
                            if (big_hdr && pos_next == hdr_end - 32'd2) begin
                                if (field_next != BPP_24) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_BPP;
                                end
                            end else if (big_hdr || pos_next == hdr_end) begin
                                if (big_hdr && field_next != 16'd0) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_COMPRESS;
                                end else if (!big_hdr && field_next != BPP_24) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_BPP;
                                end else if (size_fail) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_SIZE;
                                end else if (offset_fail) begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_OFFSET;
                                end
                            end
                        end
                    end else if (pos_next >= offset_next) begin
                        if (pad_next != 2'd0) begin
                            pad_next = pad_next - 2'd1;
                        end else if (phase_next == 2'd0) begin
                            held_next  = {8'd0, data_byte};
                            phase_next = 2'd1;
                        end else if (phase_next == 2'd1) begin
                            held_next  = held_next | {data_byte, 8'd0};
                            phase_next = 2'd2;
                        end else begin
                            phase_next = 2'd0;
                            pix_hit    = 1'b1;
                            pix_col    = col_next;
                            pix_row    = row_next;
                            if (32'(col_next) + 32'd1 >= width_next) begin
                                col_next = '0;
                                if (32'(row_next) + 32'd1 >= height_next) begin
                                    done_next = 1'b1;
                                    last_hit  = 1'b1;
                                end else begin
                                    row_next = row_next + CNT_W'(1);
                                    pad_next = width_next[1:0];
                                end
                            end else begin
                                col_next = col_next + CNT_W'(1);
                            end
                        end
                    end
                end
                if (err_hit) begin
                    err_latched_next = 1'b1;
                end
            end

            if (pos_next != '1) begin
                pos_next = pos_next + 32'd1;
            end

            // An early end of file replaces any non-final pixel
            if (end_of_file && !err_latched_next && !done_next) begin
                err_hit          = 1'b1;
                err_code         = ERR_TRUNC;
                err_latched_next = 1'b1;
                pix_hit          = 1'b0;
            end
        end
    end

    always_comb begin
        res_valid = err_hit || pix_hit;
        res       = '0;
        if (err_hit) begin
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
        end else begin
            res.kind       = KIND_PIXEL;
            res.red        = data_byte;
            res.green      = held_reg[15:8];
            res.blue       = held_reg[7:0];
            res.column     = 12'(pix_col);
            res.stored_row = 12'(pix_row);
            res.last_pixel = last_hit;
            res.error_code = ERR_MAGIC;
        end
    end

    assign stat.error_latched = err_latched_reg;
    assign stat.image_done    = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            hdr_len_reg     <= '0;
            offset_reg      <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            field_reg       <= '0;
            phase_reg       <= '0;
            held_reg        <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            pad_reg         <= '0;
            err_latched_reg <= 1'b0;
            done_reg        <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            hdr_len_reg     <= hdr_len_next;
            offset_reg      <= offset_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            field_reg       <= field_next;
            phase_reg       <= phase_next;
            held_reg        <= held_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            pad_reg         <= pad_next;
            err_latched_reg <= err_latched_next;
            done_reg        <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bmpdec_queue.sv =====
`default_nettype none

module bmpdec_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire bmpdec_pkg::result_t  push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bmpdec_pkg::result_t       out_data
);
    import bmpdec_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bmp_24bit_stream_decoder.sv =====
// 24-bit bitmap stream decoder.
// Input channel (s_): one file byte per item in s_tdata; s_tuser marks the
// first byte of a new file and clears all parse state before that byte is
// used; s_tlast marks the final byte of the file.
// Output channel (m_): one item per decoded pixel or one error item. m_tuser
// tells the two apart (0 pixel, 1 error); m_tlast flags the final pixel.
// The parser takes one byte per cycle while s_tready is high, so a pixel
// costs three input items plus row padding. Results are registered in a
// two-entry queue and are presented on m_ in the order they were produced.
// s_tready drops only when the queue is full, so a receiver that stalls
// backs the input up after two pending results; with m_tready held high the
// input never stalls.
// After an error item, all bytes are dropped until the next start of file;
// after the last pixel, remaining bytes are dropped the same way.
// Reset (aresetn low, synchronous) empties the queue and clears the parser,
// which then expects the 'BM' magic as its next two bytes.
`default_nettype none

module bmp_24bit_stream_decoder #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // data_byte
    input  wire logic                            s_tlast,  // end_of_file
    input  wire logic                            s_tuser,  // start_of_file
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [35:24] column,
    // [47:36] stored_row, [50:48] error_code, [55:51] zero
    output logic [bmpdec_pkg::TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,  // last_pixel
    output logic                                 m_tuser   // result_kind
);
    import bmpdec_pkg::*;

    logic        take;
    logic        q_full;
    logic        res_valid;
    result_t     res;
    result_t     q_out;
    parse_stat_t stat;

    // Accept a byte whenever the queue can take a result
    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    bmpdec_parse #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .data_byte     (s_tdata),
        .start_of_file (s_tuser),
        .end_of_file   (s_tlast),
        .res_valid     (res_valid),
        .res           (res),
        .stat          (stat)
    );

    bmpdec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_out)
    );

    // Pack result fields, lowest field first
    assign m_tdata = {5'd0, q_out.error_code, q_out.stored_row, q_out.column,
                      q_out.blue, q_out.green, q_out.red};
    assign m_tlast = q_out.last_pixel;
    assign m_tuser = q_out.kind;

    // Once latched or done, a byte without start of file yields nothing
    a_quiet_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !s_tuser && (stat.error_latched || stat.image_done) |-> !res_valid)
        else $error("result produced after error or end of image");

    a_error_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == KIND_ERROR) |=> stat.error_latched)
        else $error("error result did not latch");

    a_last_marks_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == KIND_PIXEL) && res.last_pixel |=> stat.image_done)
        else $error("last pixel did not mark the image done");

endmodule

`default_nettype wire
